@@ hdl/gtd_pkg.sv @@
// Shared widths, register map and reset values of the Goertzel tone detector.
package gtd_pkg;

   // Item fields and configuration register widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int LEN_W    = 13;
   localparam int ENERGY_W = 48;

   // Recurrence state and block counter
   localparam int STATE_W   = 40;
   localparam int MAX_BLOCK = 4096;
   localparam int COUNT_W   = $clog2(MAX_BLOCK);
   localparam int CMP_W     = (LEN_W > COUNT_W + 1) ? LEN_W : COUNT_W + 1;

   // Fixed point: Q1.15 coefficients, products floored by FRAC_W bits
   localparam int FRAC_W  = 15;
   localparam int CPROD_W = COEF_W + STATE_W;

   // Shared multiplier: the state is split into a low and a high slice
   localparam int LO_W    = 16;
   localparam int HI_W    = STATE_W - LO_W;
   localparam int MAG_W   = 24;
   localparam int MUL_W   = ((HI_W > MAG_W) ? HI_W : MAG_W) + 1;
   localparam int PROD_W  = 2 * MUL_W;

   // Intermediate widths
   localparam int SUM_W = CPROD_W - FRAC_W + 2;
   localparam int RE_W  = CPROD_W - FRAC_W + 1;
   localparam int IM_W  = CPROD_W - FRAC_W;

   // Configuration port
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 64;
   localparam int IDX_LSB = 3;

   typedef enum logic [1:0] {
      REG_COS = 2'd0,
      REG_SIN = 2'd1,
      REG_LEN = 2'd2,
      REG_THR = 2'd3
   } reg_index_type;

   localparam logic [COEF_W-1:0]   COS_RESET = 16'd26791;
   localparam logic [COEF_W-1:0]   SIN_RESET = 16'd18868;
   localparam logic [LEN_W-1:0]    LEN_RESET = 13'd256;
   localparam logic [ENERGY_W-1:0] THR_RESET = 48'd858993459;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

endpackage

@@ hdl/gtd_channels.sv @@
// Valid/ready channel interfaces for samples in and detection results out.
interface gtd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gtd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface gtd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gtd_pkg::ENERGY_W-1:0] energy;
   logic                         tone_detected;

   modport source (output valid, output energy, output tone_detected, input ready);
   modport sink   (input valid, input energy, input tone_detected, output ready);
endinterface

@@ hdl/goertzel_tone_detector.sv @@
// Goertzel single-bin tone detector top level with one shared multiplier.
//
//  channel   direction  transfer on          payload
//  req_chan  in         valid & ready        sample (16b signed, Q1.15)
//  rsp_chan  out        valid & ready        energy (48b, Q.30), tone_detected
//  APB       in         psel&penable&pwrite  cos_coef, sin_coef, block_length,
//                                            energy_threshold at 0x00/08/10/18
//
//  A non-closing sample runs the cos product and update states; a closing one
//  also runs the real, sin, magnitude, square, energy and result states and may
//  wait on rsp_chan. The single 25x25 multiplier sets these steps: each 16x40
//  coefficient product is built from two slices; both magnitude squares use it too.
//  reset is synchronous and returns coefficients, length, threshold, delay
//  states and counter to their defaults. A result waits in the rsp register
//  while new samples are taken; only the next block end stalls on it.
module goertzel_tone_detector (
   input  logic                          clock,
   input  logic                          reset,
   gtd_req_if.sink                       req_chan,
   gtd_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gtd_pkg::ADDR_W-1:0]    paddr,
   input  logic [gtd_pkg::DATA_W-1:0]    pwdata,
   output logic [gtd_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   typedef enum logic [3:0] {
      ST_IDLE,      // ready for a sample
      ST_COS_LO,    // cos * low slice of s1
      ST_COS_HI,    // cos * high slice of s1
      ST_COS_SUM,   // combine slices into cos * s1
      ST_UPDATE,    // new state s, shift delay line
      ST_REAL,      // real part; sin * low slice
      ST_SIN_HI,    // sin * high slice
      ST_SIN_SUM,   // combine; |re|
      ST_IMAG,      // imag part, |im|; re^2
      ST_SQ_IMAG,   // im^2
      ST_ENERGY,    // re^2 + im^2, saturated
      ST_RESULT     // load result register
   } state_type;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [gtd_pkg::COEF_W-1:0]   cos_ff;
   logic [gtd_pkg::COEF_W-1:0]   sin_ff;
   logic [gtd_pkg::LEN_W-1:0]    len_ff;
   logic [gtd_pkg::ENERGY_W-1:0] thr_ff;

   gtd_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign csr_index = gtd_pkg::reg_index_type'(paddr[gtd_pkg::ADDR_W-1:gtd_pkg::IDX_LSB]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= gtd_pkg::COS_RESET;
         sin_ff <= gtd_pkg::SIN_RESET;
         len_ff <= gtd_pkg::LEN_RESET;
         thr_ff <= gtd_pkg::THR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gtd_pkg::REG_COS: cos_ff <= pwdata[gtd_pkg::COEF_W-1:0];
            gtd_pkg::REG_SIN: sin_ff <= pwdata[gtd_pkg::COEF_W-1:0];
            gtd_pkg::REG_LEN: len_ff <= pwdata[gtd_pkg::LEN_W-1:0];
            gtd_pkg::REG_THR: thr_ff <= pwdata[gtd_pkg::ENERGY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         gtd_pkg::REG_COS: prdata = gtd_pkg::DATA_W'(cos_ff);
         gtd_pkg::REG_SIN: prdata = gtd_pkg::DATA_W'(sin_ff);
         gtd_pkg::REG_LEN: prdata = gtd_pkg::DATA_W'(len_ff);
         gtd_pkg::REG_THR: prdata = gtd_pkg::DATA_W'(thr_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------
   state_type                           state_ff, state_in;
   logic signed [gtd_pkg::STATE_W-1:0]  d1_ff, d1_in;     // s(n-1)
   logic signed [gtd_pkg::STATE_W-1:0]  d2_ff, d2_in;     // s(n-2)
   logic [gtd_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic signed [gtd_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic                                last_ff, last_in;
   logic signed [gtd_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [gtd_pkg::CPROD_W-1:0]  acc_ff, acc_in;
   logic signed [gtd_pkg::STATE_W-1:0]  s_ff, s_in;
   logic signed [gtd_pkg::RE_W-1:0]     re_ff, re_in;
   logic [gtd_pkg::MAG_W-1:0]           mre_ff, mre_in;
   logic                                ovre_ff, ovre_in;
   logic [gtd_pkg::MAG_W-1:0]           mim_ff, mim_in;
   logic                                ovim_ff, ovim_in;
   logic [gtd_pkg::ENERGY_W-1:0]        ener_ff, ener_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [gtd_pkg::ENERGY_W-1:0]        rsp_energy_ff, rsp_energy_in;
   logic                                rsp_tone_ff, rsp_tone_in;

   // ---------------------------------------------------------------
   // Shared multiplier operands
   // ---------------------------------------------------------------
   logic signed [gtd_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [gtd_pkg::MUL_W-1:0] cos_op, sin_op, lo_op, hi_op, mre_op, mim_op;
   logic signed [gtd_pkg::HI_W-1:0]  d1_hi;

   assign d1_hi  = d1_ff[gtd_pkg::STATE_W-1:gtd_pkg::LO_W];
   assign cos_op = gtd_pkg::MUL_W'($signed(cos_ff));
   assign sin_op = gtd_pkg::MUL_W'($signed(sin_ff));
   assign lo_op  = gtd_pkg::MUL_W'(d1_ff[gtd_pkg::LO_W-1:0]);   // zero-extended slice
   assign hi_op  = gtd_pkg::MUL_W'(d1_hi);                      // signed slice
   assign mre_op = gtd_pkg::MUL_W'(mre_ff);
   assign mim_op = gtd_pkg::MUL_W'(mim_ff);

   assign prod_in = mul_a * mul_b;

   // Slice product widened, and high slice product moved up by LO_W
   logic signed [gtd_pkg::CPROD_W-1:0] prod_ext, prod_shift;
   assign prod_ext   = gtd_pkg::CPROD_W'(prod_ff);
   assign prod_shift = {prod_ff[gtd_pkg::CPROD_W-gtd_pkg::LO_W-1:0], {gtd_pkg::LO_W{1'b0}}};

   // ---------------------------------------------------------------
   // New state s = sat(x + floor(cos*s1 / 2^14) - s2)
   // ---------------------------------------------------------------
   logic signed [gtd_pkg::SUM_W-2:0]   cd14;
   logic signed [gtd_pkg::IM_W-1:0]    cd15;
   logic signed [gtd_pkg::SUM_W-1:0]   s_sum;
   logic [gtd_pkg::SUM_W-gtd_pkg::STATE_W:0] s_top;
   logic signed [gtd_pkg::STATE_W-1:0] s_sat;

   assign cd14  = acc_ff[gtd_pkg::CPROD_W-1:gtd_pkg::FRAC_W-1];
   assign cd15  = acc_ff[gtd_pkg::CPROD_W-1:gtd_pkg::FRAC_W];
   assign s_sum = gtd_pkg::SUM_W'(cd14) + gtd_pkg::SUM_W'(x_ff) - gtd_pkg::SUM_W'(d2_ff);
   assign s_top = s_sum[gtd_pkg::SUM_W-1:gtd_pkg::STATE_W-1];

   always_comb begin
      if ((&s_top) || !(|s_top)) begin
         s_sat = s_sum[gtd_pkg::STATE_W-1:0];
      end else if (s_sum[gtd_pkg::SUM_W-1]) begin
         s_sat = {1'b1, {(gtd_pkg::STATE_W-1){1'b0}}};
      end else begin
         s_sat = {1'b0, {(gtd_pkg::STATE_W-1){1'b1}}};
      end
   end

   // Real and imaginary parts and their magnitudes
   logic signed [gtd_pkg::RE_W-1:0] re_calc;
   logic [gtd_pkg::RE_W-1:0]        re_abs;
   logic [gtd_pkg::IM_W-1:0]        im_abs;

   assign re_calc = gtd_pkg::RE_W'(s_ff) - gtd_pkg::RE_W'(cd15);
   assign re_abs  = re_ff[gtd_pkg::RE_W-1] ? (~re_ff) + gtd_pkg::RE_W'(1) : re_ff;
   assign im_abs  = cd15[gtd_pkg::IM_W-1] ? (~cd15) + gtd_pkg::IM_W'(1) : cd15;

   // Energy accumulate
   logic [gtd_pkg::ENERGY_W-1:0] sq_im;
   logic [gtd_pkg::ENERGY_W:0]   esum;

   assign sq_im = ovim_ff ? gtd_pkg::ENERGY_MAX : prod_ff[gtd_pkg::ENERGY_W-1:0];
   assign esum  = {1'b0, ener_ff} + {1'b0, sq_im};

   // Block end detection, with length 0 read as 1 and clamped to MAX_BLOCK
   logic [gtd_pkg::CMP_W-1:0] len_wide, len_eff, count_next;

   assign len_wide   = gtd_pkg::CMP_W'(len_ff);
   assign count_next = gtd_pkg::CMP_W'(count_ff) + gtd_pkg::CMP_W'(1);

   always_comb begin
      if (len_wide == '0) begin
         len_eff = gtd_pkg::CMP_W'(1);
      end else if (len_wide > gtd_pkg::CMP_W'(gtd_pkg::MAX_BLOCK)) begin
         len_eff = gtd_pkg::CMP_W'(gtd_pkg::MAX_BLOCK);
      end else begin
         len_eff = len_wide;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      count_in      = count_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      s_in          = s_ff;
      re_in         = re_ff;
      mre_in        = mre_ff;
      ovre_in       = ovre_ff;
      mim_in        = mim_ff;
      ovim_in       = ovim_ff;
      ener_in       = ener_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_tone_in   = rsp_tone_ff;
      mul_a         = '0;
      mul_b         = '0;

      // Result taken downstream
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x_in     = req_chan.sample;
               last_in  = (count_next >= len_eff);
               state_in = ST_COS_LO;
            end
         end
         ST_COS_LO: begin
            mul_a    = cos_op;
            mul_b    = lo_op;
            state_in = ST_COS_HI;
         end
         ST_COS_HI: begin
            mul_a    = cos_op;
            mul_b    = hi_op;
            acc_in   = prod_ext;
            state_in = ST_COS_SUM;
         end
         ST_COS_SUM: begin
            acc_in   = acc_ff + prod_shift;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (last_ff) begin
               // keep s1 intact for the imaginary part
               s_in     = s_sat;
               state_in = ST_REAL;
            end else begin
               d2_in    = d1_ff;
               d1_in    = s_sat;
               count_in = count_next[gtd_pkg::COUNT_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_REAL: begin
            re_in    = re_calc;
            mul_a    = sin_op;
            mul_b    = lo_op;
            state_in = ST_SIN_HI;
         end
         ST_SIN_HI: begin
            mul_a    = sin_op;
            mul_b    = hi_op;
            acc_in   = prod_ext;
            state_in = ST_SIN_SUM;
         end
         ST_SIN_SUM: begin
            acc_in   = acc_ff + prod_shift;
            mre_in   = re_abs[gtd_pkg::MAG_W-1:0];
            ovre_in  = |re_abs[gtd_pkg::RE_W-1:gtd_pkg::MAG_W];
            state_in = ST_IMAG;
         end
         ST_IMAG: begin
            mim_in   = im_abs[gtd_pkg::MAG_W-1:0];
            ovim_in  = |im_abs[gtd_pkg::IM_W-1:gtd_pkg::MAG_W];
            mul_a    = mre_op;
            mul_b    = mre_op;
            state_in = ST_SQ_IMAG;
         end
         ST_SQ_IMAG: begin
            // magnitude below 2^24 squares into 48 bits without overflow
            ener_in  = ovre_ff ? gtd_pkg::ENERGY_MAX : prod_ff[gtd_pkg::ENERGY_W-1:0];
            mul_a    = mim_op;
            mul_b    = mim_op;
            state_in = ST_ENERGY;
         end
         ST_ENERGY: begin
            ener_in  = esum[gtd_pkg::ENERGY_W] ? gtd_pkg::ENERGY_MAX
                                               : esum[gtd_pkg::ENERGY_W-1:0];
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // wait here only while an older result is still unclaimed
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_energy_in = ener_ff;
               rsp_tone_in   = (ener_ff >= thr_ff);
               rsp_valid_in  = 1'b1;
               d1_in         = '0;
               d2_in         = '0;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      x_ff          <= x_in;
      last_ff       <= last_in;
      s_ff          <= s_in;
      re_ff         <= re_in;
      mre_ff        <= mre_in;
      ovre_ff       <= ovre_in;
      mim_ff        <= mim_in;
      ovim_ff       <= ovim_in;
      ener_ff       <= ener_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_tone_ff   <= rsp_tone_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         d1_ff        <= '0;
         d2_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.energy        = rsp_energy_ff;
   assign rsp_chan.tone_detected = rsp_tone_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // A fresh result always comes with a cleared delay line and counter
   a_clear_at_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (d1_ff == '0 && d2_ff == '0 && count_ff == '0))
      else $error("delay state not cleared at block end");

   // A sample transfer always starts a multi-cycle pass
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("sample taken while previous one still in work");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Goertzel tone detector: random and directed samples.
`timescale 1ns / 100ps

module testbench;
   import gtd_pkg::*;

   localparam int STALL_LIMIT    = 1000;  // cycles with no transfer before giving up
   localparam int SETTLE         = 20;    // time for the last sample to finish, with margin
   localparam int RANDOM_SAMPLES = 960;
   localparam int LONG_RUN       = 300;   // samples into an oversize block, left open

   typedef struct {
      logic [ENERGY_W-1:0] energy;
      logic                tone;
   } detection_t;

   typedef enum int {WAVE_RANDOM, WAVE_SMALL, WAVE_SPARSE, WAVE_ALT, WAVE_PEAK} wave_kind;

   // Bin energy predictor plus the queue of detections still owed by the block.
   class detection_scoreboard;
      logic signed [COEF_W-1:0] cos_q;
      logic signed [COEF_W-1:0] sin_q;
      logic [LEN_W-1:0]         blk_len;
      logic [ENERGY_W-1:0]      thr;
      longint                   s1, s2;   // s(n-1), s(n-2), kept within STATE_W
      int unsigned              taken;
      detection_t               due[$];
      int unsigned              mismatches, samples, blocks, saturated, tones;

      function new();
         cos_q   = COS_RESET;
         sin_q   = SIN_RESET;
         blk_len = LEN_RESET;
         thr     = THR_RESET;
      endfunction

      function void set_reg(reg_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_COS: cos_q   = value[COEF_W-1:0];
            REG_SIN: sin_q   = value[COEF_W-1:0];
            REG_LEN: blk_len = value[LEN_W-1:0];
            REG_THR: thr     = value[ENERGY_W-1:0];
         endcase
      endfunction

      // |v| at or beyond 2^24 squares past the energy range
      function logic [ENERGY_W-1:0] square_sat(longint v);
         longint m;
         m = (v < 0) ? -v : v;
         if (m >= (longint'(1) << 24)) return ENERGY_MAX;
         return ENERGY_W'(m * m);
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x);
         longint              p_cos, p_sin, s, re, im, lim;
         logic [ENERGY_W:0]   e;
         int unsigned         len_eff;
         detection_t          d;
         lim = (longint'(1) << (STATE_W - 1)) - 1;
         len_eff = (blk_len == 0) ? 1 : (blk_len > MAX_BLOCK) ? MAX_BLOCK : blk_len;
         samples++;
         // arithmetic shift on the exact product is the floor
         p_cos = longint'(cos_q) * s1;
         p_sin = longint'(sin_q) * s1;
         s = longint'(x) + (p_cos >>> (FRAC_W - 1)) - s2;
         if (s > lim) s = lim;
         else if (s < -lim - 1) s = -lim - 1;
         re = s - (p_cos >>> FRAC_W);
         im = p_sin >>> FRAC_W;
         s2 = s1;
         s1 = s;
         // a lowered length ends the block on the next sample
         if (taken + 1 < len_eff) begin
            taken++;
            return;
         end
         e = {1'b0, square_sat(re)} + {1'b0, square_sat(im)};
         d.energy = e[ENERGY_W] ? ENERGY_MAX : e[ENERGY_W-1:0];
         d.tone   = (d.energy >= thr);
         due.push_back(d);
         s1    = 0;
         s2    = 0;
         taken = 0;
      endfunction

      function void check_result(logic [ENERGY_W-1:0] energy, logic tone);
         detection_t d;
         if (due.size() == 0) begin
            $error("result with no block outstanding: energy %0d, tone_detected %0b",
                   energy, tone);
            mismatches++;
            return;
         end
         d = due.pop_front();
         blocks++;
         if (d.energy == ENERGY_MAX) saturated++;
         if (d.tone) tones++;
         if (energy !== d.energy) begin
            $error("energy mismatch: expected %0d, actual %0d", d.energy, energy);
            mismatches++;
         end
         if (tone !== d.tone) begin
            $error("tone_detected mismatch: expected %0b, actual %0b", d.tone, tone);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel, penable, pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata, prdata;
   logic                pready;
   bit                  steady = 1'b0;   // no idling on either side while set
   int unsigned         stall_cycles = 0;
   int unsigned         sent = 0;
   int unsigned         csr_writes = 0;
   detection_scoreboard sb = new();

   gtd_req_if req_bus();
   gtd_rsp_if rsp_bus();

   goertzel_tone_detector uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // Result side: back-pressure in about a fifth of the cycles.
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 21);
   end

   // Transfer monitor and watchdog. Everything is driven with NBAs at the edge,
   // so here we see the values that were present at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_sample(req_bus.sample);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.energy, rsp_bus.tone_detected);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d detections outstanding",
                     STALL_LIMIT, sb.due.size());
            $display("Regression FAIL");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Random upper bits above the register width; the block must drop them.
   function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] v, int w);
      logic [DATA_W-1:0] m;
      m = {DATA_W{1'b1}} << w;
      return ({$urandom, $urandom} & m) | (v & ~m);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(wave_kind wave, int k);
      case (wave)
         WAVE_SMALL:  return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         WAVE_SPARSE: return ($urandom_range(9) == 0) ? SAMPLE_W'($urandom) : '0;
         WAVE_ALT:    return k[0] ? 16'sh8000 : 16'sh7fff;  // Nyquist, full scale
         WAVE_PEAK:   return 16'sh7fff;                     // DC, full scale
         default:     return SAMPLE_W'($urandom);
      endcase
   endfunction

   // One sample transfer; valid stays high afterward so back-to-back items
   // never need a low-high pair in the same step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      while (!steady && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // Sender holds off until the block has returned every detection owed.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.due.size() != 0) @(posedge clock);
   endtask

   // Drained, plus time for a sample that closes no block to finish.
   task automatic settle();
      drain();
      repeat (SETTLE) @(posedge clock);
   endtask

   // Setup then access cycle; an idle cycle after keeps psel from toggling
   // twice in one step when writes follow each other.
   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx) << IDX_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned       n, len_eff, phase, random_sent, pick;
      logic [COEF_W-1:0] cos_v, sin_v;
      logic [LEN_W-1:0]  len_v;
      logic [ENERGY_W-1:0] thr_v;
      wave_kind          wave;

      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one 256-sample block, field extremes up front.
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      repeat (252) send_sample(pick_sample(WAVE_RANDOM, 0));
      settle();

      // Zero length acts as one sample per block; zero threshold always detects.
      csr_write(REG_COS, 64'h7fff);
      csr_write(REG_SIN, 64'hffff_ffff_ffff_8000);
      csr_write(REG_LEN, 64'd0);
      csr_write(REG_THR, 64'd0);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'shffff);
      send_sample(16'sh0001);
      send_sample(16'sh0000);
      settle();

      // Length lowered below the count mid-block: the next sample closes it.
      csr_write(REG_COS, 64'h8000);
      csr_write(REG_SIN, 64'h7fff);
      csr_write(REG_LEN, 64'd8);
      csr_write(REG_THR, 64'(ENERGY_MAX));
      for (int k = 0; k < 6; k++) send_sample(pick_sample(WAVE_ALT, k));
      settle();
      csr_write(REG_LEN, 64'd3);
      send_sample(16'sh7fff);
      settle();

      // Largest length register value: a long block left open, closed by the
      // first sample under the next settings.
      csr_write(REG_COS, with_noise(64'($urandom), COEF_W));
      csr_write(REG_SIN, with_noise(64'($urandom), COEF_W));
      csr_write(REG_LEN, 64'({LEN_W{1'b1}}));
      csr_write(REG_THR, 64'({$urandom, $urandom} >> $urandom_range(16, 63)));
      repeat (LONG_RUN) send_sample(pick_sample(WAVE_RANDOM, 0));
      settle();

      // Random phases: new settings, a few whole blocks, sometimes a partial
      // block left open for the next settings to inherit.
      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_SAMPLES) begin
         steady <= (phase >= 8 && phase < 14);
         pick = $urandom_range(9);
         if (pick < 8) begin
            cos_v = COEF_W'($urandom);
            sin_v = COEF_W'($urandom);
            case ($urandom_range(19))
               0:       len_v = '0;
               1, 2:    len_v = LEN_W'($urandom_range(13, 64));
               default: len_v = LEN_W'($urandom_range(1, 12));
            endcase
            thr_v = ENERGY_W'({$urandom, $urandom} >> $urandom_range(16, 63));
            wave  = wave_kind'($urandom_range(4));
         end else begin
            // near-resonant bin at full scale drives the energy into saturation
            cos_v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            sin_v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            len_v = LEN_W'($urandom_range(24, 64));
            thr_v = $urandom_range(1) ? ENERGY_MAX
                                      : ENERGY_W'({$urandom, $urandom} >> $urandom_range(16, 40));
            wave  = (cos_v == 16'h8000) ? WAVE_ALT : WAVE_PEAK;
         end
         csr_write(REG_COS, with_noise(64'(cos_v), COEF_W));
         csr_write(REG_SIN, with_noise(64'(sin_v), COEF_W));
         csr_write(REG_LEN, with_noise(64'(len_v), LEN_W));
         csr_write(REG_THR, with_noise(64'(thr_v), ENERGY_W));

         len_eff = (len_v == 0) ? 1 : len_v;
         n = $urandom_range(1, 3) * len_eff;
         if ($urandom_range(3) == 0) n += $urandom_range(0, len_eff - 1);
         for (int k = 0; k < n; k++) begin
            send_sample(pick_sample(wave, k));
            if ($urandom_range(63) == 0) drain();
         end
         random_sent += n;
         settle();
         phase++;
      end
      steady <= 1'b0;
      settle();

      $display("Run covered %0d samples, %0d blocks checked, %0d register writes,",
               sb.samples, sb.blocks, csr_writes);
      $display("  %0d blocks with saturated energy and %0d with a tone detected.",
               sb.saturated, sb.tones);
      if (sb.mismatches == 0 && sb.due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
